FILE: design/assert_macros.svh
// Assertion helpers shared by the RTL; clocked on clk, quiet while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Check that cons holds in the cycle after ante
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

FILE: design/lmbr_pkg.sv
`default_nettype none

package lmbr_pkg;

    // Coordinate width default
    localparam int COORD_BITS_DEF = 32;

    // Configuration register widths and reset values
    localparam int CFG_W      = 31;
    localparam int MT_W       = 16;
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_W-1:0] CUBE_RST   = 31'd13107200;
    localparam logic [CFG_W-1:0] RANGE_RST  = 31'd19660800;
    localparam logic [MT_W-1:0]  THRESH_RST = 16'd384;

    // Derived value widths
    localparam int HALF_W = CFG_W - 1;
    localparam int PROD_W = MT_W + CFG_W;
    localparam int THR_W  = PROD_W - 8;
    localparam int MOV_W  = THR_W + 2;

    // Divide-by-five unit: biased dividend width and bias position
    localparam int DIV_W      = 45;
    localparam int DIV_BIAS_B = 42;

    // Depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_CUBE   = 2'd0,
        REG_RANGE  = 2'd1,
        REG_THRESH = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        KIND_INIT   = 2'd0,
        KIND_HOLD   = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_BOX    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CLS_INIT = 2'd0,
        CLS_HOLD = 2'd1,
        CLS_MOVE = 2'd2
    } cls_t;

    typedef enum logic [2:0] {
        PU_MUL   = 3'd0,
        PU_PREP  = 3'd1,
        PU_SER1  = 3'd2,
        PU_SER2  = 3'd3,
        PU_SER3  = 3'd4,
        PU_FIX   = 3'd5,
        PU_DONE  = 3'd6,
        PU_READY = 3'd7
    } pu_state_t;

    // Classified command control bits
    typedef struct packed {
        cls_t       cls;
        logic [2:0] move;
        logic [2:0] down;
    } cmd_ctrl_t;

    // Step values derived from the configuration
    typedef struct packed {
        logic                    ready;
        logic [HALF_W-1:0]       half;
        logic [THR_W-1:0]        thr;
        logic signed [MOV_W-1:0] mov;
    } step_t;

endpackage

`default_nettype wire

FILE: design/lmbr_cfg_unit.sv
`default_nettype none

module lmbr_cfg_unit
    import lmbr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]      cfg_data,
    output step_t                      step
);

    localparam logic [DIV_W-1:0] DIV_BIAS = DIV_W'(5) << DIV_BIAS_B;
    localparam logic [DIV_W-2:0] A_BIAS   = (DIV_W-1)'(1) << DIV_BIAS_B;

    pu_state_t               state_reg, state_next;
    logic [CFG_W-1:0]        cube_reg;
    logic [CFG_W-1:0]        range_reg;
    logic [MT_W-1:0]         thresh_reg;
    logic [THR_W-1:0]        thr_reg;
    logic [DIV_W-1:0]        div_reg;
    logic [DIV_W-1:0]        quo_reg;
    logic signed [MOV_W-1:0] mov_reg;

    logic [PROD_W-1:0]       prod;
    logic [MOV_W-1:0]        diff;
    logic [DIV_W-1:0]        nine;
    logic [DIV_W-1:0]        dividend;
    logic [DIV_W-1:0]        q0;
    logic [DIV_W-1:0]        q1;
    logic [DIV_W-1:0]        q2;
    logic [DIV_W-1:0]        q3;
    logic [DIV_W-1:0]        q4;
    logic [3:0]              rem4;
    logic [1:0]              corr;
    logic [DIV_W-2:0]        a_full;
    logic signed [MOV_W-1:0] a_val;
    logic signed [MOV_W-1:0] b_val;
    logic signed [MOV_W-1:0] mov_val;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cube_reg   <= CUBE_RST;
            range_reg  <= RANGE_RST;
            thresh_reg <= THRESH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_CUBE:   cube_reg   <= cfg_data;
                REG_RANGE:  range_reg  <= cfg_data;
                REG_THRESH: thresh_reg <= cfg_data[MT_W-1:0];
                default:    ;
            endcase
        end
    end

    // Sequence: multiply, prepare dividend, divide in stages, pick move distance
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            PU_MUL:   state_next = PU_PREP;
            PU_PREP:  state_next = PU_SER1;
            PU_SER1:  state_next = PU_SER2;
            PU_SER2:  state_next = PU_SER3;
            PU_SER3:  state_next = PU_FIX;
            PU_FIX:   state_next = PU_DONE;
            PU_DONE:  state_next = PU_READY;
            PU_READY: state_next = PU_READY;
            default:  state_next = PU_MUL;
        endcase
        if (cfg_we)
        begin
            state_next = PU_MUL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PU_MUL;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Threshold product and a = floor(9 * (cube - 2*thr) / 20) prep
    always_comb
    begin
        prod     = PROD_W'(thresh_reg) * PROD_W'(range_reg);
        diff     = MOV_W'(cube_reg) - {1'b0, thr_reg, 1'b0};
        nine     = {{1{diff[MOV_W-1]}}, diff, 3'b000} + {{4{diff[MOV_W-1]}}, diff};
        dividend = {{2{nine[DIV_W-1]}}, nine[DIV_W-1:2]} + DIV_BIAS;
    end

    // Divide by five: x * 0.8 as a shift-and-add series, then quarter it;
    // the estimate is at most two low, fixed from the low remainder bits
    always_comb
    begin
        q0   = {1'b0, div_reg[DIV_W-1:1]} + {2'b00, div_reg[DIV_W-1:2]};
        q1   = q0 + {4'b0000, q0[DIV_W-1:4]};
        q2   = quo_reg + {8'h00, quo_reg[DIV_W-1:8]};
        q3   = q2 + {16'h0000, q2[DIV_W-1:16]};
        q4   = quo_reg + {32'h0000_0000, quo_reg[DIV_W-1:32]};
        rem4 = div_reg[3:0] - {quo_reg[1:0], 2'b00} - quo_reg[3:0];
        if (rem4 >= 4'd10)
            corr = 2'd2;
        else if (rem4 >= 4'd5)
            corr = 2'd1;
        else
            corr = 2'd0;
    end

    // Move distance = max(a, thr - range)
    always_comb
    begin
        a_full  = quo_reg[DIV_W-2:0] - A_BIAS;
        a_val   = $signed(a_full[MOV_W-1:0]);
        b_val   = $signed(MOV_W'(thr_reg) - MOV_W'(range_reg));
        mov_val = (a_val > b_val) ? a_val : b_val;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            PU_MUL:
            begin
                thr_reg <= prod[PROD_W-1:8];
            end
            PU_PREP:
            begin
                div_reg <= dividend;
            end
            PU_SER1:
            begin
                quo_reg <= q1;
            end
            PU_SER2:
            begin
                quo_reg <= q3;
            end
            PU_SER3:
            begin
                quo_reg <= {2'b00, q4[DIV_W-1:2]};
            end
            PU_FIX:
            begin
                quo_reg <= quo_reg + DIV_W'(corr);
            end
            PU_DONE:
            begin
                mov_reg <= mov_val;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        step.ready = (state_reg == PU_READY);
        step.half  = cube_reg[CFG_W-1:1];
        step.thr   = thr_reg;
        step.mov   = mov_reg;
    end

endmodule

`default_nettype wire

FILE: design/lmbr_queue.sv
`default_nettype none

module lmbr_queue
    import lmbr_pkg::*;
#(
    parameter int DATA_W = 8,
    parameter int DEPTH  = QUEUE_DEPTH
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire logic [DATA_W-1:0] wr_data,
    output logic                   full,
    input  wire logic              rd_en,
    output logic [DATA_W-1:0]      rd_data,
    output logic                   empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_wr;
    logic              do_rd;

    always_comb
    begin
        full    = (count_reg == CNT_W'(DEPTH));
        empty   = (count_reg == '0);
        do_wr   = wr_en && !full;
        do_rd   = rd_en && !empty;
        rd_data = mem_reg[rd_ptr_reg];
    end

    // Advance pointers with wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the entry
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

FILE: design/lmbr_front.sv
`default_nettype none

module lmbr_front
    import lmbr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    output logic                            full,
    input  wire logic [2:0][COORD_BITS-1:0] pos,
    input  wire step_t                      step,
    input  wire logic                       q_full,
    output logic                            cmd_push,
    output cmd_ctrl_t                       cmd_ctrl,
    output logic [2:0][COORD_BITS-1:0]      cmd_old_lo,
    output logic [2:0][COORD_BITS-1:0]      cmd_old_hi,
    output logic [2:0][COORD_BITS-1:0]      cmd_new_lo,
    output logic [2:0][COORD_BITS-1:0]      cmd_new_hi
);

    localparam int W     = COORD_BITS;
    localparam int SUM_W = ((W > MOV_W) ? W : MOV_W) + 2;
    localparam int CMP_W = (((W + 1) > THR_W) ? (W + 1) : THR_W) + 1;

    logic                 box_valid_reg;
    logic [2:0][W-1:0]    box_lo_reg;
    logic [2:0][W-1:0]    box_hi_reg;

    logic [2:0][W-1:0]    new_lo;
    logic [2:0][W-1:0]    new_hi;
    logic [2:0]           near_lo;
    logic [2:0]           near_hi;
    logic [2:0]           move;
    logic                 accept;

    // Clamp a wide sum into the coordinate range
    function automatic logic [W-1:0] sat(input logic [SUM_W-1:0] v);
        logic fits;
        fits = (v[SUM_W-1:W-1] == {(SUM_W-W+1){v[SUM_W-1]}});
        if (fits)
            return v[W-1:0];
        else if (v[SUM_W-1])
            return {1'b1, {(W-1){1'b0}}};
        else
            return {1'b0, {(W-1){1'b1}}};
    endfunction

    // Per axis: initial cube, face tests, shifted bounds
    for (genvar i = 0; i < 3; i++)
    begin : g_axis
        logic [SUM_W-1:0] p_ext;
        logic [SUM_W-1:0] lo_ext;
        logic [SUM_W-1:0] hi_ext;
        logic [SUM_W-1:0] mov_ext;
        logic [SUM_W-1:0] half_ext;
        logic [W:0]       d_lo;
        logic [W:0]       d_hi;
        logic [W:0]       m_lo;
        logic [W:0]       m_hi;
        logic [W-1:0]     dn_lo;
        logic [W-1:0]     dn_hi;
        logic [W-1:0]     up_lo;
        logic [W-1:0]     up_hi;

        assign p_ext    = {{(SUM_W-W){pos[i][W-1]}}, pos[i]};
        assign lo_ext   = {{(SUM_W-W){box_lo_reg[i][W-1]}}, box_lo_reg[i]};
        assign hi_ext   = {{(SUM_W-W){box_hi_reg[i][W-1]}}, box_hi_reg[i]};
        assign mov_ext  = {{(SUM_W-MOV_W){step.mov[MOV_W-1]}}, step.mov};
        assign half_ext = {{(SUM_W-HALF_W){1'b0}}, step.half};

        assign d_lo = {pos[i][W-1], pos[i]} - {box_lo_reg[i][W-1], box_lo_reg[i]};
        assign d_hi = {pos[i][W-1], pos[i]} - {box_hi_reg[i][W-1], box_hi_reg[i]};
        assign m_lo = d_lo[W] ? (~d_lo + 1'b1) : d_lo;
        assign m_hi = d_hi[W] ? (~d_hi + 1'b1) : d_hi;

        assign near_lo[i] = ({{(CMP_W-W-1){1'b0}}, m_lo} <= {{(CMP_W-THR_W){1'b0}}, step.thr});
        assign near_hi[i] = ({{(CMP_W-W-1){1'b0}}, m_hi} <= {{(CMP_W-THR_W){1'b0}}, step.thr});
        assign move[i]    = near_lo[i] || near_hi[i];

        assign dn_lo = sat(lo_ext - mov_ext);
        assign dn_hi = sat(hi_ext - mov_ext);
        assign up_lo = sat(lo_ext + mov_ext);
        assign up_hi = sat(hi_ext + mov_ext);

        always_comb
        begin
            if (!box_valid_reg)
            begin
                new_lo[i] = sat(p_ext - half_ext);
                new_hi[i] = sat(p_ext + half_ext);
            end
            else if (near_lo[i])
            begin
                new_lo[i] = dn_lo;
                new_hi[i] = dn_hi;
            end
            else if (near_hi[i])
            begin
                new_lo[i] = up_lo;
                new_hi[i] = up_hi;
            end
            else
            begin
                new_lo[i] = box_lo_reg[i];
                new_hi[i] = box_hi_reg[i];
            end
        end
    end

    // Classify the position and hand the command to the queue
    always_comb
    begin
        full     = q_full || !step.ready;
        accept   = push && !full;
        cmd_push = accept;
        if (!box_valid_reg)
            cmd_ctrl.cls = CLS_INIT;
        else if (move != 3'b000)
            cmd_ctrl.cls = CLS_MOVE;
        else
            cmd_ctrl.cls = CLS_HOLD;
        cmd_ctrl.move = move;
        cmd_ctrl.down = near_lo;
        cmd_old_lo    = box_lo_reg;
        cmd_old_hi    = box_hi_reg;
        cmd_new_lo    = new_lo;
        cmd_new_hi    = new_hi;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            box_valid_reg <= 1'b1;
        end
    end

    // Update the box on every accepted position
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            box_lo_reg <= new_lo;
            box_hi_reg <= new_hi;
        end
    end

endmodule

`default_nettype wire

FILE: design/lmbr_back.sv
`default_nettype none

module lmbr_back
    import lmbr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cmd_valid,
    output logic                            cmd_pop,
    input  wire cmd_ctrl_t                  cmd_ctrl,
    input  wire logic [2:0][COORD_BITS-1:0] cmd_old_lo,
    input  wire logic [2:0][COORD_BITS-1:0] cmd_old_hi,
    input  wire logic [2:0][COORD_BITS-1:0] cmd_new_lo,
    input  wire logic [2:0][COORD_BITS-1:0] cmd_new_hi,
    output logic                            empty,
    input  wire logic                       pop,
    output kind_t                           res_kind,
    output logic [2:0][COORD_BITS-1:0]      res_lo,
    output logic [2:0][COORD_BITS-1:0]      res_hi,
    output logic                            res_last
);

    logic                       res_valid_reg, res_valid_next;
    kind_t                      res_kind_reg;
    logic [2:0][COORD_BITS-1:0] res_lo_reg;
    logic [2:0][COORD_BITS-1:0] res_hi_reg;
    logic                       res_last_reg;
    logic [2:0]                 done_reg, done_next;

    logic                       load;
    logic                       issue;
    logic [2:0]                 remain;
    logic [2:0]                 sel;
    kind_t                      kind_c;
    logic [2:0][COORD_BITS-1:0] lo_c;
    logic [2:0][COORD_BITS-1:0] hi_c;
    logic                       last_c;

    // Pick the next result of the head command
    always_comb
    begin
        load   = !res_valid_reg || pop;
        issue  = load && cmd_valid;
        remain = cmd_ctrl.move & ~done_reg;
        sel    = remain & (~remain + 3'd1);
        kind_c = KIND_BOX;
        lo_c   = cmd_new_lo;
        hi_c   = cmd_new_hi;
        last_c = 1'b1;
        case (cmd_ctrl.cls)
            CLS_INIT:
            begin
                kind_c = KIND_INIT;
            end
            CLS_HOLD:
            begin
                kind_c = KIND_HOLD;
                lo_c   = cmd_old_lo;
                hi_c   = cmd_old_hi;
            end
            CLS_MOVE:
            begin
                if (remain != 3'b000)
                begin
                    kind_c = KIND_REMOVE;
                    last_c = 1'b0;
                    lo_c   = cmd_old_lo;
                    hi_c   = cmd_old_hi;
                    for (int i = 0; i < 3; i++)
                    begin
                        if (sel[i] && cmd_ctrl.down[i])
                            lo_c[i] = cmd_new_hi[i];
                        else if (sel[i])
                            hi_c[i] = cmd_new_lo[i];
                    end
                end
            end
            default: ;
        endcase
        cmd_pop        = issue && last_c;
        done_next      = done_reg;
        res_valid_next = res_valid_reg;
        if (issue)
        begin
            done_next      = last_c ? 3'b000 : (done_reg | sel);
            res_valid_next = 1'b1;
        end
        else if (pop)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            done_reg      <= 3'b000;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            done_reg      <= done_next;
        end
    end

    // Load the output register
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            res_kind_reg <= kind_c;
            res_lo_reg   <= lo_c;
            res_hi_reg   <= hi_c;
            res_last_reg <= last_c;
        end
    end

    always_comb
    begin
        empty    = !res_valid_reg;
        res_kind = res_kind_reg;
        res_lo   = res_lo_reg;
        res_hi   = res_hi_reg;
        res_last = res_last_reg;
    end

endmodule

`default_nettype wire

FILE: design/local_map_box_recenter_unit.sv
// Local map box recenter unit.
// Input queue side: pos_x, pos_y, pos_z transfer when push is high and full is low.
// Result queue side: the oldest result sits on kind, min_*, max_*, last while empty
// is low and transfers when pop is high. Each position gives one to four results,
// the final one flagged by last.
// Configuration: cfg_we writes cfg_data into the register cfg_addr selects
// (0 cube length, 1 detection range, 2 move threshold); write only while idle.
// A transferred position is written into the command queue, and its results then
// load the output register, one per cycle while pop stays high; they leave one at
// a time through that single register. A two-entry command queue lets positions
// keep transferring while results wait to be popped.
// After reset and after every configuration write, full stays high while the step
// unit recomputes the threshold and move distance: multiply, prepare the dividend,
// the staged shift-and-add divide by five, its correction and the final pick.
// Reset clears the box, so the first position after reset initialises a new cube.
// When pop stays low, results hold, the command queue fills and full rises.
`default_nettype none
`include "assert_macros.svh"

module local_map_box_recenter_unit
    import lmbr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]        cfg_addr,
    input  wire logic [CFG_W-1:0]             cfg_data,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic signed [COORD_BITS-1:0] pos_x,
    input  wire logic signed [COORD_BITS-1:0] pos_y,
    input  wire logic signed [COORD_BITS-1:0] pos_z,
    output logic                              empty,
    input  wire logic                         pop,
    output logic [1:0]                        kind,
    output logic signed [COORD_BITS-1:0]      min_x,
    output logic signed [COORD_BITS-1:0]      min_y,
    output logic signed [COORD_BITS-1:0]      min_z,
    output logic signed [COORD_BITS-1:0]      max_x,
    output logic signed [COORD_BITS-1:0]      max_y,
    output logic signed [COORD_BITS-1:0]      max_z,
    output logic                              last
);

    localparam int CMD_W = $bits(cmd_ctrl_t) + 12 * COORD_BITS;

    step_t                      step;
    logic [2:0][COORD_BITS-1:0] pos;
    logic                       q_full;
    logic                       q_empty;
    logic                       cmd_push;
    logic                       cmd_pop;
    cmd_ctrl_t                  wr_ctrl, rd_ctrl;
    logic [2:0][COORD_BITS-1:0] wr_old_lo, wr_old_hi, wr_new_lo, wr_new_hi;
    logic [2:0][COORD_BITS-1:0] rd_old_lo, rd_old_hi, rd_new_lo, rd_new_hi;
    logic [CMD_W-1:0]           q_wdata;
    logic [CMD_W-1:0]           q_rdata;
    kind_t                      res_kind;
    logic [2:0][COORD_BITS-1:0] res_lo;
    logic [2:0][COORD_BITS-1:0] res_hi;

    assign pos = {pos_z, pos_y, pos_x};

    lmbr_cfg_unit u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .step     (step)
    );

    lmbr_front #(.COORD_BITS(COORD_BITS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .pos        (pos),
        .step       (step),
        .q_full     (q_full),
        .cmd_push   (cmd_push),
        .cmd_ctrl   (wr_ctrl),
        .cmd_old_lo (wr_old_lo),
        .cmd_old_hi (wr_old_hi),
        .cmd_new_lo (wr_new_lo),
        .cmd_new_hi (wr_new_hi)
    );

    // Pack and unpack commands around the queue
    assign q_wdata = {wr_ctrl, wr_old_lo, wr_old_hi, wr_new_lo, wr_new_hi};
    assign {rd_ctrl, rd_old_lo, rd_old_hi, rd_new_lo, rd_new_hi} = q_rdata;

    lmbr_queue #(.DATA_W(CMD_W), .DEPTH(QUEUE_DEPTH)) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (q_wdata),
        .full    (q_full),
        .rd_en   (cmd_pop),
        .rd_data (q_rdata),
        .empty   (q_empty)
    );

    lmbr_back #(.COORD_BITS(COORD_BITS)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (!q_empty),
        .cmd_pop    (cmd_pop),
        .cmd_ctrl   (rd_ctrl),
        .cmd_old_lo (rd_old_lo),
        .cmd_old_hi (rd_old_hi),
        .cmd_new_lo (rd_new_lo),
        .cmd_new_hi (rd_new_hi),
        .empty      (empty),
        .pop        (pop),
        .res_kind   (res_kind),
        .res_lo     (res_lo),
        .res_hi     (res_hi),
        .res_last   (last)
    );

    assign kind  = res_kind;
    assign min_x = res_lo[0];
    assign min_y = res_lo[1];
    assign min_z = res_lo[2];
    assign max_x = res_hi[0];
    assign max_y = res_hi[1];
    assign max_z = res_hi[2];

    // Only removal regions are non-final results
    `ASSERT_IMPLIES(a_last_matches_kind, !empty, last == (res_kind != KIND_REMOVE))
    // A configuration write blocks input while step values are rebuilt
    `ASSERT_NEXT(a_cfg_blocks_input, cfg_we, full)
    // A pending removal region keeps its command at the queue head
    `ASSERT_IMPLIES(a_remove_keeps_cmd, !empty && res_kind == KIND_REMOVE, !q_empty)

endmodule

`default_nettype wire
